[hw/rtl/fibf_pkg.sv]
package fibf_pkg;

    // Image parsing phase
    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_BODY    = 3'd2,
        PH_FRAME   = 3'd3,
        PH_PAD     = 3'd4,
        PH_TRAILER = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_BYTES = 2'd0,
        CFG_PAD_BYTES   = 2'd1,
        CFG_BLOCK_TAG   = 2'd2,
        CFG_END_TAG     = 2'd3
    } t_cfg_idx;

    localparam logic [12:0] FRAME_BYTES_RST = 13'd263;
    localparam logic [12:0] PAD_BYTES_RST   = 13'd15;
    localparam logic [7:0]  BLOCK_TAG_RST   = 8'hEC;
    localparam logic [7:0]  END_TAG_RST     = 8'hF7;
    localparam logic [15:0] CRC_POLY        = 16'h8005;

    localparam logic [16:0] LEAD_BYTES      = 17'd16;
    localparam logic [16:0] PREAMBLE_BYTES  = 17'd4;
    localparam logic [16:0] TRAILER_BYTES   = 17'd16;
    localparam logic [16:0] CMD_HDR_BYTES   = 17'd4;

    // Output slots of one work descriptor, in emission order
    localparam int NSLOTS       = 7;
    localparam int SLOT_LEN_HI  = 0;
    localparam int SLOT_LEN_LO  = 1;
    localparam int SLOT_HDR_TAG = 2;
    localparam int SLOT_HDR_MID = 3;
    localparam int SLOT_HDR_LOW = 4;
    localparam int SLOT_DATA    = 5;
    localparam int SLOT_CRC     = 6;
    localparam int SLOT_W       = $clog2(NSLOTS);

    // Front-to-back work descriptor
    typedef struct packed {
        logic [NSLOTS-1:0] slots;
        logic [15:0]       len_bits;
        logic [23:0]       hdr;
        logic [7:0]        data;
        logic [15:0]       crc;
    } t_desc;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

endpackage

[hw/rtl/fibf_front.sv]
module fibf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_fire,
    input  logic [7:0]          i_in_byte,
    input  logic                i_image_end,
    output logic                o_push,
    output fibf_pkg::t_desc     o_desc
);

    logic [12:0]      r_frame_bytes;
    logic [12:0]      r_pad_bytes;
    logic [7:0]       r_block_tag;
    logic [7:0]       r_end_tag;

    fibf_pkg::t_phase r_phase, n_phase;
    logic [16:0]      r_fc, n_fc;
    logic [16:0]      r_ft, n_ft;
    logic [15:0]      r_fl, n_fl;
    logic [23:0]      r_hdr, n_hdr;
    logic [7:0]       r_tag, n_tag;
    logic [15:0]      r_crc, n_crc;

    function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ fibf_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= fibf_pkg::FRAME_BYTES_RST;
            r_pad_bytes   <= fibf_pkg::PAD_BYTES_RST;
            r_block_tag   <= fibf_pkg::BLOCK_TAG_RST;
            r_end_tag     <= fibf_pkg::END_TAG_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fibf_pkg::CFG_FRAME_BYTES: r_frame_bytes <= i_cfg_data[12:0];
                fibf_pkg::CFG_PAD_BYTES:   r_pad_bytes   <= i_cfg_data[12:0];
                fibf_pkg::CFG_BLOCK_TAG:   r_block_tag   <= i_cfg_data[7:0];
                fibf_pkg::CFG_END_TAG:     r_end_tag     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fibf_pkg::PH_LEAD;
            r_fc    <= '0;
            r_ft    <= '0;
            r_fl    <= '0;
            r_hdr   <= '0;
            r_tag   <= '0;
            r_crc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_fc    <= n_fc;
            r_ft    <= n_ft;
            r_fl    <= n_fl;
            r_hdr   <= n_hdr;
            r_tag   <= n_tag;
            r_crc   <= n_crc;
        end
    end

    always_comb begin
        logic [15:0] crc_new;
        logic [7:0]  tag;
        logic [15:0] size;
        logic [16:0] total;
        logic [16:0] ft_eff;
        logic [16:0] fc_new;
        logic        closed;

        n_phase = r_phase;
        n_fc    = r_fc;
        n_ft    = r_ft;
        n_fl    = r_fl;
        n_hdr   = r_hdr;
        n_tag   = r_tag;
        n_crc   = r_crc;
        o_desc  = '0;
        crc_new = crc_step(r_crc, i_in_byte);
        tag     = r_hdr[23:16];
        size    = {r_hdr[7:0], i_in_byte};
        total   = (tag == r_block_tag) ? fibf_pkg::CMD_HDR_BYTES
                                       : {1'b0, size} + fibf_pkg::CMD_HDR_BYTES;
        ft_eff  = r_ft;
        fc_new  = r_fc + 17'd1;
        closed  = 1'b0;

        if (i_fire) begin
            if (r_phase == fibf_pkg::PH_DONE) begin
                // trailer finished: bytes dropped until image end
                if (i_image_end) begin
                    n_phase = fibf_pkg::PH_LEAD;
                    n_fc    = '0;
                    n_ft    = '0;
                    n_fl    = '0;
                    n_hdr   = '0;
                    n_tag   = '0;
                    n_crc   = '0;
                end
            end else begin
                n_crc = crc_new;
                if (r_phase == fibf_pkg::PH_HEADER) begin
                    if (r_fc < 17'd3) begin
                        n_hdr = {r_hdr[15:0], i_in_byte};
                        n_fc  = fc_new;
                    end else begin
                        o_desc.len_bits = {total[12:0], 3'b000};
                        o_desc.hdr      = r_hdr;
                        o_desc.data     = i_in_byte;
                        o_desc.slots[fibf_pkg::SLOT_LEN_HI]  = 1'b1;
                        o_desc.slots[fibf_pkg::SLOT_LEN_LO]  = 1'b1;
                        o_desc.slots[fibf_pkg::SLOT_HDR_TAG] = 1'b1;
                        o_desc.slots[fibf_pkg::SLOT_HDR_MID] = 1'b1;
                        o_desc.slots[fibf_pkg::SLOT_HDR_LOW] = 1'b1;
                        o_desc.slots[fibf_pkg::SLOT_DATA]    = 1'b1;
                        n_tag = tag;
                        n_ft  = total;
                        n_fc  = fibf_pkg::CMD_HDR_BYTES;
                        if (tag == r_end_tag) begin
                            n_fl = '0;
                            if (total > fibf_pkg::CMD_HDR_BYTES) begin
                                n_phase = fibf_pkg::PH_BODY;
                            end else begin
                                n_phase = fibf_pkg::PH_TRAILER;
                                n_fc    = '0;
                            end
                        end else if (tag == r_block_tag) begin
                            n_phase = fibf_pkg::PH_FRAME;
                            n_fl    = size;
                            n_fc    = '0;
                        end else if (total <= fibf_pkg::CMD_HDR_BYTES) begin
                            n_fc = '0;
                        end else begin
                            n_phase = fibf_pkg::PH_BODY;
                        end
                    end
                end else begin
                    if (r_fc == '0) begin
                        case (r_phase)
                            fibf_pkg::PH_LEAD:
                                ft_eff = (r_fl < 16'd2) ? fibf_pkg::LEAD_BYTES
                                                        : fibf_pkg::PREAMBLE_BYTES;
                            fibf_pkg::PH_FRAME:
                                ft_eff = {4'b0, (r_frame_bytes == '0) ? 13'd1 : r_frame_bytes};
                            fibf_pkg::PH_PAD:
                                ft_eff = {4'b0, (r_pad_bytes == '0) ? 13'd1 : r_pad_bytes};
                            default:
                                ft_eff = fibf_pkg::TRAILER_BYTES;
                        endcase
                        n_ft = ft_eff;
                        o_desc.len_bits = {ft_eff[12:0], 3'b000};
                        o_desc.slots[fibf_pkg::SLOT_LEN_HI] = 1'b1;
                        o_desc.slots[fibf_pkg::SLOT_LEN_LO] = 1'b1;
                    end
                    o_desc.data = i_in_byte;
                    o_desc.slots[fibf_pkg::SLOT_DATA] = 1'b1;
                    n_fc = fc_new;
                    if (fc_new >= ft_eff) begin
                        n_fc = '0;
                        case (r_phase)
                            fibf_pkg::PH_LEAD: begin
                                if (r_fl >= 16'd2) begin
                                    n_phase = fibf_pkg::PH_HEADER;
                                    n_fl    = '0;
                                end else begin
                                    n_fl = r_fl + 16'd1;
                                end
                            end
                            fibf_pkg::PH_BODY: begin
                                n_phase = (r_tag == r_end_tag) ? fibf_pkg::PH_TRAILER
                                                               : fibf_pkg::PH_HEADER;
                                n_fl    = '0;
                            end
                            fibf_pkg::PH_FRAME: begin
                                n_fl = r_fl - 16'd1;
                                if (r_fl == 16'd1) n_phase = fibf_pkg::PH_PAD;
                            end
                            fibf_pkg::PH_PAD: begin
                                n_phase = fibf_pkg::PH_HEADER;
                            end
                            default: begin
                                if (r_fl >= 16'd1) begin
                                    n_phase = fibf_pkg::PH_DONE;
                                    n_fl    = '0;
                                    closed  = 1'b1;
                                end else begin
                                    n_fl = r_fl + 16'd1;
                                end
                            end
                        endcase
                    end
                end

                if (closed || i_image_end) begin
                    o_desc.crc = crc_new;
                    o_desc.slots[fibf_pkg::SLOT_CRC] = 1'b1;
                end
                if (i_image_end) begin
                    n_phase = fibf_pkg::PH_LEAD;
                    n_fc    = '0;
                    n_ft    = '0;
                    n_fl    = '0;
                    n_hdr   = '0;
                    n_tag   = '0;
                    n_crc   = '0;
                end
            end
        end
    end

    assign o_push = i_fire && (o_desc.slots != '0);

endmodule

[hw/rtl/fibf_queue.sv]
module fibf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fibf_pkg::t_desc i_desc,
    output logic            o_full,
    input  logic            i_pop,
    output fibf_pkg::t_desc o_head,
    output logic            o_head_valid
);

    fibf_pkg::t_desc                r_mem [fibf_pkg::QDEPTH];
    logic [fibf_pkg::QAW-1:0]       r_wp;
    logic [fibf_pkg::QAW-1:0]       r_rp;
    logic [fibf_pkg::QCW-1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + fibf_pkg::QCW'(i_push) - fibf_pkg::QCW'(i_pop);
        end
    end

    assign o_full       = (r_cnt == fibf_pkg::QCW'(fibf_pkg::QDEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];

endmodule

[hw/rtl/fibf_back.sv]
module fibf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fibf_pkg::t_desc i_head,
    input  logic            i_head_valid,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_crc_valid,
    output logic [15:0]     o_crc_value,
    output logic            o_run_last
);

    logic [fibf_pkg::NSLOTS-1:0] r_done, n_done;
    logic [fibf_pkg::NSLOTS-1:0] pend;
    logic [fibf_pkg::NSLOTS-1:0] sel_oh;
    logic [fibf_pkg::SLOT_W-1:0] sel;
    logic                        last;
    logic                        load;
    logic                        emit;
    logic [7:0]                  sel_byte;

    logic                        r_valid;
    logic [7:0]                  r_byte;
    logic                        r_bv;
    logic                        r_cv;
    logic [15:0]                 r_crc;
    logic                        r_last;

    assign pend = i_head.slots & ~r_done;

    // lowest pending slot goes next
    always_comb begin
        sel = '0;
        for (int i = fibf_pkg::NSLOTS - 1; i >= 0; i--) begin
            if (pend[i]) sel = fibf_pkg::SLOT_W'(i);
        end
    end

    assign sel_oh = fibf_pkg::NSLOTS'(1) << sel;
    assign last   = ((pend & ~sel_oh) == '0);
    assign load   = !r_valid || !i_out_stall;
    assign emit   = load && i_head_valid;
    assign o_pop  = emit && last;

    always_comb begin
        case (sel)
            fibf_pkg::SLOT_W'(fibf_pkg::SLOT_LEN_HI):  sel_byte = i_head.len_bits[15:8];
            fibf_pkg::SLOT_W'(fibf_pkg::SLOT_LEN_LO):  sel_byte = i_head.len_bits[7:0];
            fibf_pkg::SLOT_W'(fibf_pkg::SLOT_HDR_TAG): sel_byte = i_head.hdr[23:16];
            fibf_pkg::SLOT_W'(fibf_pkg::SLOT_HDR_MID): sel_byte = i_head.hdr[15:8];
            fibf_pkg::SLOT_W'(fibf_pkg::SLOT_HDR_LOW): sel_byte = i_head.hdr[7:0];
            fibf_pkg::SLOT_W'(fibf_pkg::SLOT_DATA):    sel_byte = i_head.data;
            default:                                   sel_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_done = r_done;
        if (emit) n_done = last ? '0 : (r_done | sel_oh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_done <= n_done;
            if (load) r_valid <= i_head_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= sel_byte;
            r_last <= last;
            if (sel == fibf_pkg::SLOT_W'(fibf_pkg::SLOT_CRC)) begin
                r_bv  <= 1'b0;
                r_cv  <= 1'b1;
                r_crc <= i_head.crc;
            end else begin
                r_bv  <= 1'b1;
                r_cv  <= 1'b0;
                r_crc <= 16'h0000;
            end
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_byte;
    assign o_byte_valid = r_bv;
    assign o_crc_valid  = r_cv;
    assign o_crc_value  = r_crc;
    assign o_run_last   = r_last;

endmodule

[hw/rtl/flash_image_to_bitstream_framer_top.sv]
// Channel   Direction  Handshake                  Word
// in        input      i_in_valid / o_in_stall    i_in_byte, i_image_end
// out       output     o_out_valid / i_out_stall  o_out_byte, o_byte_valid, o_crc_valid,
//                                                 o_crc_value, o_run_last
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One input word is taken per cycle while the descriptor queue has room; one
// output word leaves per cycle while i_out_stall is low, so the rate is set by the
// output side: an input word yields k output words (0 to 7) there.
// Command header completion gives 6 or 7 words, field starts give 3 or 4.
// Reset is synchronous, active low; config returns to its defaults.
// Output stall backs up the 4-entry queue, then raises o_in_stall.
module flash_image_to_bitstream_framer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_image_end,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_crc_valid,
    output logic [15:0] o_crc_value,
    output logic        o_run_last
);

    logic            w_fire;
    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_head_valid;
    fibf_pkg::t_desc w_desc;
    fibf_pkg::t_desc w_head;

    // config is always taken; the user must write only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    // input side stalls only on a full queue
    assign o_in_stall = w_full;
    assign w_fire     = i_in_valid && !w_full;

    // front: parse state, CRC, builds at most one descriptor per input word
    fibf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_fire),
        .i_in_byte   (i_in_byte),
        .i_image_end (i_image_end),
        .o_push      (w_push),
        .o_desc      (w_desc)
    );

    // decouples parse from emission
    fibf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_desc       (w_desc),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid)
    );

    // back: expands each descriptor into output words, one per cycle while not stalled
    fibf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_crc_valid  (o_crc_valid),
        .o_crc_value  (o_crc_value),
        .o_run_last   (o_run_last)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("descriptor pushed into full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid) else $error("pop from empty queue");

    a_crc_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_crc_valid) |-> (o_run_last && !o_byte_valid))
        else $error("CRC word not last of its run");
`endif

endmodule
